// ===== rtl/itlp_pkg.sv =====
// Shared types, constants and decode helpers for the instruction trace line parser.
`timescale 1ns / 1ps

package itlp_pkg;

    // Largest instruction length in bytes and the number of byte slots on the ports
    localparam int MAX_INSN_BYTES_DEF = 15;
    localparam int BYTE_SLOTS         = 15;

    // Line status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_BLANK     = 4'd1;
    localparam logic [3:0] ST_ZERO_PC   = 4'd2;
    localparam logic [3:0] ST_NO_OPEN   = 4'd3;
    localparam logic [3:0] ST_NO_CLOSE  = 4'd4;
    localparam logic [3:0] ST_NO_SPACE1 = 4'd5;
    localparam logic [3:0] ST_NO_SPACE2 = 4'd6;
    localparam logic [3:0] ST_BAD_LEN   = 4'd7;
    localparam logic [3:0] ST_NO_SPACE3 = 4'd8;

    // Characters that the fixed checks look for
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    // Saturation limit of the decimal length
    localparam logic [4:0] LEN_SAT    = 5'd31;
    // Saturation limit of the significant digit count of one byte
    localparam logic [4:0] DIGITS_SAT = 5'd17;
    localparam logic [4:0] DIGITS_MAX = 5'd16;

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_SKIP_PID,
        PH_PC_WS,
        PH_PC_DIG,
        PH_OPEN,
        PH_CLOSE,
        PH_SPACE1,
        PH_SKIP_ILEN,
        PH_SPACE2,
        PH_LEN_WS,
        PH_LEN_DIG,
        PH_SKIP_INSN,
        PH_SPACE3,
        PH_BYTE_WS,
        PH_BYTE_DIG,
        PH_DONE
    } phase_t;

    // Parser state carried from one character to the next
    typedef struct packed {
        phase_t      phase;
        logic [2:0]  skip_count;
        logic [63:0] pc_acc;
        logic [4:0]  len_acc;
        logic [3:0]  byte_index;
        logic [7:0]  byte_value;
        logic        byte_overflow;
        logic [4:0]  byte_digits;
        logic [3:0]  error_code;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:         PH_LEAD,
        skip_count:    3'd0,
        pc_acc:        64'd0,
        len_acc:       5'd0,
        byte_index:    4'd0,
        byte_value:    8'd0,
        byte_overflow: 1'b0,
        byte_digits:   5'd0,
        error_code:    ST_OK
    };

    // Hex digit decode: bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Space, tab, LF, VT, FF, CR
    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    // Shift in one hex digit, saturating at all ones
    function automatic logic [63:0] pc_add(input logic [63:0] pc, input logic [3:0] d);
        return (pc[63:60] != 4'd0) ? {64{1'b1}} : {pc[59:0], d};
    endfunction

endpackage

// ===== rtl/instruction_trace_line_parser.sv =====
// Top level of the instruction trace line parser: input register, parser state, result register.
// A line's final character is loaded into the input register when accepted; the line's result
// is loaded into the result register when that character advances from the input register.
// Throughput: one character per cycle; only a line-end item waits while an untaken result
// occupies the result register.
// Reset: asynchronous, active low; clears the parser state, stored bytes and both valids.
`timescale 1ns / 1ps

module instruction_trace_line_parser #(
    parameter int MAX_INSN_BYTES = itlp_pkg::MAX_INSN_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [63:0] pc,
    output logic [3:0]  length,
    output logic [63:0] bytes_low,
    output logic [55:0] bytes_high
);
    import itlp_pkg::*;

    // Input register
    logic        in_valid_reg;
    logic [7:0]  in_ch_reg;
    logic        in_last_reg;

    // Parser state
    state_t                         state_reg;
    state_t                         state_next;
    logic [MAX_INSN_BYTES-1:0][7:0] bytes_reg;
    logic [MAX_INSN_BYTES-1:0][7:0] bytes_next;

    // Result register
    logic        out_valid_reg;
    logic [3:0]  status_reg;
    logic [63:0] pc_reg;
    logic [3:0]  length_reg;
    logic [63:0] bytes_low_reg;
    logic [55:0] bytes_high_reg;

    logic [3:0]  res_status;
    logic [3:0]  res_length;
    logic [63:0] res_low;
    logic [55:0] res_high;

    logic        out_free;
    logic        advance;
    logic        emit;

    // Flow control: a character moves on unless it ends a line and the result slot is busy
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign emit     = advance && in_last_reg;
    assign in_ready = !in_valid_reg || advance;

    itlp_step #(
        .MAX_INSN_BYTES (MAX_INSN_BYTES)
    ) u_step (
        .cur       (state_reg),
        .cur_bytes (bytes_reg),
        .ch        (in_ch_reg),
        .last_char (in_last_reg),
        .nxt       (state_next),
        .nxt_bytes (bytes_next)
    );

    itlp_result #(
        .MAX_INSN_BYTES (MAX_INSN_BYTES)
    ) u_result (
        .st         (state_next),
        .st_bytes   (bytes_next),
        .status     (res_status),
        .length     (res_length),
        .bytes_low  (res_low),
        .bytes_high (res_high)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            in_ch_reg   <= ch;
            in_last_reg <= last_char;
        end
    end

    // Parser state; everything returns to reset after a line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= STATE_RESET;
            bytes_reg <= '0;
        end
        else if (advance) begin
            state_reg <= in_last_reg ? STATE_RESET : state_next;
            bytes_reg <= in_last_reg ? '0 : bytes_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (emit) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            status_reg     <= res_status;
            pc_reg         <= state_next.pc_acc;
            length_reg     <= res_length;
            bytes_low_reg  <= res_low;
            bytes_high_reg <= res_high;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign pc         = pc_reg;
    assign length     = length_reg;
    assign bytes_low  = bytes_low_reg;
    assign bytes_high = bytes_high_reg;

    // A delivered line leaves the parser back at its reset state
    a_reset_after_line: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (state_reg.phase == PH_LEAD) && (state_reg.error_code == ST_OK)
                 && (state_reg.pc_acc == 64'd0) && (bytes_reg == '0))
        else $error("parser state not cleared after line end");

    // A good line always carries a length inside the legal range
    a_ok_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_OK)) |->
            (length_reg != 4'd0) && ({1'b0, length_reg} <= 5'(MAX_INSN_BYTES)))
        else $error("ok status with bad length");

    // A failed line carries no length and no bytes
    a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_OK)) |->
            (length_reg == 4'd0) && (bytes_low_reg == 64'd0) && (bytes_high_reg == 56'd0))
        else $error("failed line carries payload");

    // Only codes that mid-line checks can raise are ever recorded
    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.error_code == ST_OK) || (state_reg.error_code == ST_ZERO_PC)
        || (state_reg.error_code == ST_NO_OPEN) || (state_reg.error_code == ST_NO_SPACE1)
        || (state_reg.error_code == ST_NO_SPACE2) || (state_reg.error_code == ST_BAD_LEN)
        || (state_reg.error_code == ST_NO_SPACE3))
        else $error("unexpected recorded error code");

endmodule

// ===== rtl/itlp_step.sv =====
// Per-character parser update: phase walk, hex and decimal accumulation, byte stores.
`timescale 1ns / 1ps

module itlp_step #(
    parameter int MAX_INSN_BYTES = itlp_pkg::MAX_INSN_BYTES_DEF
) (
    input  itlp_pkg::state_t                cur,
    input  logic [MAX_INSN_BYTES-1:0][7:0]  cur_bytes,
    input  logic [7:0]                      ch,
    input  logic                            last_char,
    output itlp_pkg::state_t                nxt,
    output logic [MAX_INSN_BYTES-1:0][7:0]  nxt_bytes
);
    import itlp_pkg::*;

    localparam logic [4:0] MAX_LEN = 5'(MAX_INSN_BYTES);

    always_comb
    begin
        state_t                        s;
        logic [MAX_INSN_BYTES-1:0][7:0] b;
        logic [4:0]                    h;
        logic                          hv;
        logic [3:0]                    hd;
        logic                          ws;
        logic                          do_add;
        logic                          do_store;
        logic [3:0]                    idx_inc;
        logic [8:0]                    len_mul;
        logic                          len_ok;

        s        = cur;
        b        = cur_bytes;
        h        = hex_decode(ch);
        hv       = h[4];
        hd       = h[3:0];
        ws       = is_ws(ch);
        do_add   = 1'b0;
        do_store = 1'b0;
        idx_inc  = cur.byte_index + 4'd1;
        len_mul  = {1'b0, cur.len_acc, 3'b000} + {3'b000, cur.len_acc, 1'b0}
                 + {5'd0, ch[3:0]};
        len_ok   = (cur.len_acc >= 5'd1) && (cur.len_acc <= MAX_LEN);

        // Phase walk; an error freezes everything until line end
        if (cur.error_code == ST_OK) begin
            case (cur.phase)
                PH_LEAD:
                begin
                    if (ch != CH_SPACE) begin
                        s.skip_count = 3'd4;
                        s.phase      = PH_SKIP_PID;
                    end
                end
                PH_SKIP_PID:
                begin
                    s.skip_count = cur.skip_count - 3'd1;
                    if (s.skip_count == 3'd0) s.phase = PH_PC_WS;
                end
                PH_PC_WS:
                begin
                    if (!ws) begin
                        if (!hv) begin
                            s.error_code = ST_ZERO_PC;
                        end
                        else begin
                            s.pc_acc = pc_add(cur.pc_acc, hd);
                            s.phase  = PH_PC_DIG;
                        end
                    end
                end
                PH_PC_DIG:
                begin
                    if (hv)                      s.pc_acc     = pc_add(cur.pc_acc, hd);
                    else if (cur.pc_acc == 64'd0) s.error_code = ST_ZERO_PC;
                    else                         s.phase      = PH_OPEN;
                end
                PH_OPEN:
                begin
                    if (ch == CH_OPEN) s.phase      = PH_CLOSE;
                    else               s.error_code = ST_NO_OPEN;
                end
                PH_CLOSE:
                begin
                    if (ch == CH_CLOSE) s.phase = PH_SPACE1;
                end
                PH_SPACE1:
                begin
                    if (ch == CH_SPACE) begin
                        s.skip_count = 3'd5;
                        s.phase      = PH_SKIP_ILEN;
                    end
                    else begin
                        s.error_code = ST_NO_SPACE1;
                    end
                end
                PH_SKIP_ILEN:
                begin
                    s.skip_count = cur.skip_count - 3'd1;
                    if (s.skip_count == 3'd0) s.phase = PH_SPACE2;
                end
                PH_SPACE2:
                begin
                    if (ch == CH_SPACE) s.phase      = PH_LEN_WS;
                    else                s.error_code = ST_NO_SPACE2;
                end
                PH_LEN_WS:
                begin
                    if (!ws) begin
                        if (is_dec(ch)) begin
                            s.len_acc = {1'b0, ch[3:0]};
                            s.phase   = PH_LEN_DIG;
                        end
                        else begin
                            s.error_code = ST_BAD_LEN;
                        end
                    end
                end
                PH_LEN_DIG:
                begin
                    if (is_dec(ch)) begin
                        s.len_acc = (len_mul > {4'd0, LEN_SAT}) ? LEN_SAT : len_mul[4:0];
                    end
                    else if (!len_ok) begin
                        s.error_code = ST_BAD_LEN;
                    end
                    else begin
                        s.skip_count = 3'd5;
                        s.phase      = PH_SKIP_INSN;
                    end
                end
                PH_SKIP_INSN:
                begin
                    s.skip_count = cur.skip_count - 3'd1;
                    if (s.skip_count == 3'd0) s.phase = PH_SPACE3;
                end
                PH_SPACE3:
                begin
                    if (ch == CH_SPACE) s.phase      = PH_BYTE_WS;
                    else                s.error_code = ST_NO_SPACE3;
                end
                PH_BYTE_WS:
                begin
                    if ({1'b0, cur.byte_index} >= cur.len_acc) begin
                        s.phase = PH_DONE;
                    end
                    else if (!ws) begin
                        if (!hv) begin
                            s.phase = PH_DONE;
                        end
                        else begin
                            do_add  = 1'b1;
                            s.phase = PH_BYTE_DIG;
                        end
                    end
                end
                PH_BYTE_DIG:
                begin
                    if (hv) begin
                        do_add = 1'b1;
                    end
                    else begin
                        do_store = 1'b1;
                        if (({1'b0, idx_inc} >= cur.len_acc) || !ws) s.phase = PH_DONE;
                        else                                         s.phase = PH_BYTE_WS;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Shift a hex digit into the current byte; count significant digits
        if (do_add) begin
            s.byte_value = {s.byte_value[3:0], hd};
            if ((s.byte_digits != 5'd0) || (hd != 4'd0)) begin
                if (s.byte_digits < DIGITS_SAT) s.byte_digits = s.byte_digits + 5'd1;
                if (s.byte_digits > DIGITS_MAX) s.byte_overflow = 1'b1;
            end
        end

        // Store the byte on its terminator, or at line end while a byte is open
        if (do_store || (last_char && (s.error_code == ST_OK) && (s.phase == PH_BYTE_DIG))) begin
            for (int i = 0; i < MAX_INSN_BYTES; i++) begin
                if ((s.byte_index == 4'(i)) && ({1'b0, s.byte_index} < s.len_acc)) begin
                    b[i] = s.byte_overflow ? 8'hFF : s.byte_value;
                end
            end
            s.byte_index    = s.byte_index + 4'd1;
            s.byte_value    = 8'd0;
            s.byte_overflow = 1'b0;
            s.byte_digits   = 5'd0;
        end

        nxt       = s;
        nxt_bytes = b;
    end

endmodule

// ===== rtl/itlp_result.sv =====
// Line-end status decode and packing of the instruction bytes.
`timescale 1ns / 1ps

module itlp_result #(
    parameter int MAX_INSN_BYTES = itlp_pkg::MAX_INSN_BYTES_DEF
) (
    input  itlp_pkg::state_t                st,
    input  logic [MAX_INSN_BYTES-1:0][7:0]  st_bytes,
    output logic [3:0]                      status,
    output logic [3:0]                      length,
    output logic [63:0]                     bytes_low,
    output logic [55:0]                     bytes_high
);
    import itlp_pkg::*;

    localparam logic [4:0] MAX_LEN = 5'(MAX_INSN_BYTES);

    logic                      len_ok;
    logic [BYTE_SLOTS*8-1:0]   packed_bytes;

    assign len_ok = (st.len_acc >= 5'd1) && (st.len_acc <= MAX_LEN);

    // Status: a recorded error wins, else the phase the line stopped in
    always_comb
    begin
        if (st.error_code != ST_OK) begin
            status = st.error_code;
        end
        else begin
            case (st.phase)
                PH_LEAD:                   status = ST_BLANK;
                PH_SKIP_PID, PH_PC_WS:     status = ST_ZERO_PC;
                PH_PC_DIG:                 status = (st.pc_acc == 64'd0) ? ST_ZERO_PC : ST_NO_OPEN;
                PH_OPEN:                   status = ST_NO_OPEN;
                PH_CLOSE:                  status = ST_NO_CLOSE;
                PH_SPACE1:                 status = ST_NO_SPACE1;
                PH_SKIP_ILEN, PH_SPACE2:   status = ST_NO_SPACE2;
                PH_LEN_WS:                 status = ST_BAD_LEN;
                PH_LEN_DIG:                status = len_ok ? ST_NO_SPACE3 : ST_BAD_LEN;
                PH_SKIP_INSN, PH_SPACE3:   status = ST_NO_SPACE3;
                default:                   status = ST_OK;
            endcase
        end
    end

    // Pack bytes, slots past the configured maximum stay zero
    always_comb
    begin
        packed_bytes = '0;
        for (int i = 0; i < MAX_INSN_BYTES; i++) begin
            packed_bytes[i*8 +: 8] = st_bytes[i];
        end
    end

    assign length     = (status == ST_OK) ? st.len_acc[3:0] : 4'd0;
    assign bytes_low  = (status == ST_OK) ? packed_bytes[63:0] : 64'd0;
    assign bytes_high = (status == ST_OK) ? packed_bytes[BYTE_SLOTS*8-1:64] : 56'd0;

endmodule
